>>> hw/rtl/rtst_pkg.sv
// ---------------------------------------------------------------------------
// rtst_pkg
// Types, codes and sizes shared by the region timer statistics table.
// ---------------------------------------------------------------------------
`default_nettype none

package rtst_pkg;

   localparam int SLOT_COUNT_DEF = 32;
   localparam int KEY_BITS_DEF   = 16;

   localparam int REGION_BITS    = 16;
   localparam int TICK_BITS      = 63;
   localparam int CALL_BITS      = 32;
   localparam int SLOT_OUT_BITS  = 5;
   localparam int CMD_BITS       = 2;
   localparam int STATUS_BITS    = 2;

   // region_id and timestamp packed, padded to whole bytes
   localparam int REQ_DATA_BITS  = 80;
   localparam int REQ_PAD_BITS   = REQ_DATA_BITS - REGION_BITS - TICK_BITS;
   localparam int RSP_FIELD_BITS = STATUS_BITS + SLOT_OUT_BITS + 6 * TICK_BITS + CALL_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_DATA_BITS - RSP_FIELD_BITS;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_BEGIN = 2'd0,
      CMD_END   = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NOTFOUND = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LOAD,
      ST_FETCH,
      ST_CALC,
      ST_APPLY,
      ST_WRITE,
      ST_REPLY
   } state_type;

   // one operation of the shared adder per step of an end event
   typedef enum logic [2:0] {
      STEP_ELAPSED,
      STEP_SUM,
      STEP_LO_FIRST,
      STEP_LO_SECOND,
      STEP_HI_FIRST,
      STEP_HI_SECOND
   } step_type;

   typedef struct packed {
      logic [TICK_BITS-1:0] stamp;
      logic [TICK_BITS-1:0] sum;
      logic [CALL_BITS-1:0] calls;
      logic [TICK_BITS-1:0] lo_first;
      logic [TICK_BITS-1:0] lo_second;
      logic [TICK_BITS-1:0] hi_first;
      logic [TICK_BITS-1:0] hi_second;
   } rec_type;

   // laid out so that status sits in the lowest bits
   typedef struct packed {
      logic [RSP_PAD_BITS-1:0]  pad;
      logic [TICK_BITS-1:0]     max_second;
      logic [TICK_BITS-1:0]     max_first;
      logic [TICK_BITS-1:0]     min_second;
      logic [TICK_BITS-1:0]     min_first;
      logic [CALL_BITS-1:0]     call_total;
      logic [TICK_BITS-1:0]     total_ticks;
      logic [TICK_BITS-1:0]     elapsed_ticks;
      logic [SLOT_OUT_BITS-1:0] slot_index;
      status_type               status;
   } rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/region_timer_stats_table.sv
// ---------------------------------------------------------------------------
// region_timer_stats_table
// Table of timing slots keyed by region id, with min/max/total statistics.
// ---------------------------------------------------------------------------
// One word is taken at a time and req_tready is high only while the block is
// idle. A begin, end or read walks the key store one slot per cycle from slot
// 0 and stops at the matching slot; an end event then runs six passes through
// one shared 63-bit adder (elapsed time, total, and four compares against the
// stored minima and maxima). The result register frees the input side while a
// reply waits to be taken. Slot valid bits live in flip-flops and are cleared
// at once by reset or by the clear command; keys and statistics live in
// memories.
`default_nettype none

module region_timer_stats_table #(
   parameter int SLOT_COUNT = rtst_pkg::SLOT_COUNT_DEF,
   parameter int KEY_BITS   = rtst_pkg::KEY_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // region_id [15:0], timestamp [78:16], zero pad [79]
   input  wire  [rtst_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // cmd [1:0]
   input  wire  [rtst_pkg::CMD_BITS-1:0]    req_tuser,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // status [1:0], slot_index [6:2], elapsed_ticks [69:7], total_ticks [132:70],
   // call_total [164:133], min_first [227:165], min_second [290:228],
   // max_first [353:291], max_second [416:354], zero pad [423:417]
   output logic [rtst_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   import rtst_pkg::*;

   localparam int IdxBits   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int KeyInBits = (KEY_BITS < REGION_BITS) ? KEY_BITS : REGION_BITS;
   localparam logic [IdxBits:0]   ScanEnd  = (IdxBits + 1)'(SLOT_COUNT);
   localparam logic [IdxBits-1:0] LastSlot = IdxBits'(SLOT_COUNT - 1);

   // input word fields
   cmd_type              cmd_in;
   logic [KEY_BITS-1:0]  key_in;
   logic [TICK_BITS-1:0] ts_in;

   assign cmd_in = cmd_type'(req_tuser);
   assign key_in = KEY_BITS'(req_tdata[KeyInBits-1:0]);
   assign ts_in  = req_tdata[REGION_BITS +: TICK_BITS];

   // control and working registers
   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in_reg;
   logic [KEY_BITS-1:0]  key_ff, key_in_reg;
   logic [TICK_BITS-1:0] ts_ff, ts_in_reg;
   logic [IdxBits:0]     scan_ff, scan_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [IdxBits-1:0]   cmp_idx_ff, cmp_idx_in;
   logic                 free_ff, free_in;
   logic [IdxBits-1:0]   free_idx_ff, free_idx_in;
   logic [IdxBits-1:0]   sel_idx_ff, sel_idx_in;
   status_type           status_ff, status_in;
   rec_type              rec_ff, rec_in;
   logic [TICK_BITS-1:0] el_ff, el_in;
   step_type             step_ff, step_in;
   logic [3:0]           flag_ff, flag_in;
   logic [SLOT_COUNT-1:0] used_ff, used_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   rsp_type              rsp_ff, rsp_in;

   // memories
   logic [KEY_BITS-1:0]  key_mem [SLOT_COUNT];
   logic [KEY_BITS-1:0]  key_rd_ff;
   logic                 key_we;
   logic [IdxBits-1:0]   key_waddr;
   rec_type              rec_mem [SLOT_COUNT];
   rec_type              rec_rd_ff;
   logic                 rec_we;

   // shared adder / comparator
   logic [TICK_BITS-1:0] alu_a, alu_b;
   logic                 alu_sub;
   logic [TICK_BITS:0]   alu_res;

   assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                  + (TICK_BITS + 1)'(alu_sub);

   // scan helpers
   logic                 used_cur;
   logic                 hit_now;
   logic                 free_now;
   logic [IdxBits-1:0]   free_idx_now;

   assign used_cur     = used_ff[cmp_idx_ff];
   assign hit_now      = cmp_vld_ff && used_cur && (key_rd_ff == key_ff);
   assign free_now     = free_ff || (cmp_vld_ff && !used_cur);
   assign free_idx_now = free_ff ? free_idx_ff : cmp_idx_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_ff;

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_ff;
      end
      key_rd_ff <= key_mem[scan_ff[IdxBits-1:0]];
   end

   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[sel_idx_ff] <= rec_ff;
      end
      rec_rd_ff <= rec_mem[sel_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         cmp_vld_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         cmp_vld_ff    <= cmp_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      cmd_ff      <= cmd_in_reg;
      key_ff      <= key_in_reg;
      ts_ff       <= ts_in_reg;
      scan_ff     <= scan_in;
      cmp_idx_ff  <= cmp_idx_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      sel_idx_ff  <= sel_idx_in;
      status_ff   <= status_in;
      rec_ff      <= rec_in;
      el_ff       <= el_in;
      step_ff     <= step_in;
      flag_ff     <= flag_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in_reg    = cmd_ff;
      key_in_reg    = key_ff;
      ts_in_reg     = ts_ff;
      scan_in       = scan_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      sel_idx_in    = sel_idx_ff;
      status_in     = status_ff;
      rec_in        = rec_ff;
      el_in         = el_ff;
      step_in       = step_ff;
      flag_in       = flag_ff;
      used_in       = used_ff;
      rsp_in        = rsp_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      key_we        = 1'b0;
      key_waddr     = free_idx_now;
      rec_we        = 1'b0;
      alu_a         = '0;
      alu_b         = '0;
      alu_sub       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in_reg = cmd_in;
               key_in_reg = key_in;
               ts_in_reg  = ts_in;
               status_in  = STATUS_OK;
               el_in      = '0;
               scan_in    = '0;
               free_in    = 1'b0;
               if (cmd_in == CMD_CLEAR) begin
                  used_in  = '0;
                  state_in = ST_REPLY;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // key store read is registered, so it lags the scan address and lines up with cmp_idx_ff
            if (scan_ff < ScanEnd) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[IdxBits-1:0];
               scan_in    = scan_ff + 1'b1;
            end
            free_in     = free_now;
            free_idx_in = free_idx_now;
            if (hit_now) begin
               sel_idx_in = cmp_idx_ff;
               cmp_vld_in = 1'b0;
               state_in   = ST_LOAD;
            end else if (cmp_vld_ff && (cmp_idx_ff == LastSlot)) begin
               cmp_vld_in = 1'b0;
               if (cmd_ff != CMD_BEGIN) begin
                  status_in = STATUS_NOTFOUND;
                  state_in  = ST_REPLY;
               end else if (free_now) begin
                  // claim the lowest free slot with fresh statistics
                  key_we                = 1'b1;
                  used_in[free_idx_now] = 1'b1;
                  sel_idx_in            = free_idx_now;
                  rec_in.stamp          = ts_ff;
                  rec_in.sum            = '0;
                  rec_in.calls          = '0;
                  rec_in.lo_first       = '1;
                  rec_in.lo_second      = '1;
                  rec_in.hi_first       = '0;
                  rec_in.hi_second      = '0;
                  state_in              = ST_WRITE;
               end else begin
                  status_in = STATUS_FULL;
                  state_in  = ST_REPLY;
               end
            end
         end

         ST_LOAD: begin
            state_in = ST_FETCH;
         end

         ST_FETCH: begin
            rec_in = rec_rd_ff;
            unique case (cmd_ff)
               CMD_BEGIN: begin
                  rec_in.stamp = ts_ff;
                  state_in     = ST_WRITE;
               end
               CMD_END: begin
                  step_in  = STEP_ELAPSED;
                  state_in = ST_CALC;
               end
               default: begin
                  state_in = ST_REPLY;
               end
            endcase
         end

         ST_CALC: begin
            unique case (step_ff)
               STEP_ELAPSED: begin
                  alu_a   = ts_ff;
                  alu_b   = rec_ff.stamp;
                  alu_sub = 1'b1;
                  el_in   = alu_res[TICK_BITS-1:0];
                  step_in = STEP_SUM;
               end
               STEP_SUM: begin
                  alu_a      = rec_ff.sum;
                  alu_b      = el_ff;
                  rec_in.sum = alu_res[TICK_BITS] ? '1 : alu_res[TICK_BITS-1:0];
                  step_in    = STEP_LO_FIRST;
               end
               // a - b without carry out means a < b
               STEP_LO_FIRST: begin
                  alu_a      = el_ff;
                  alu_b      = rec_ff.lo_first;
                  alu_sub    = 1'b1;
                  flag_in[0] = !alu_res[TICK_BITS];
                  step_in    = STEP_LO_SECOND;
               end
               STEP_LO_SECOND: begin
                  alu_a      = el_ff;
                  alu_b      = rec_ff.lo_second;
                  alu_sub    = 1'b1;
                  flag_in[1] = !alu_res[TICK_BITS];
                  step_in    = STEP_HI_FIRST;
               end
               STEP_HI_FIRST: begin
                  alu_a      = rec_ff.hi_first;
                  alu_b      = el_ff;
                  alu_sub    = 1'b1;
                  flag_in[2] = !alu_res[TICK_BITS];
                  step_in    = STEP_HI_SECOND;
               end
               STEP_HI_SECOND: begin
                  alu_a      = rec_ff.hi_second;
                  alu_b      = el_ff;
                  alu_sub    = 1'b1;
                  flag_in[3] = !alu_res[TICK_BITS];
                  state_in   = ST_APPLY;
               end
               default: begin
                  state_in = ST_APPLY;
               end
            endcase
         end

         ST_APPLY: begin
            if (flag_ff[0]) begin
               rec_in.lo_second = rec_ff.lo_first;
               rec_in.lo_first  = el_ff;
            end else if (flag_ff[1]) begin
               rec_in.lo_second = el_ff;
            end
            if (flag_ff[2]) begin
               rec_in.hi_second = rec_ff.hi_first;
               rec_in.hi_first  = el_ff;
            end else if (flag_ff[3]) begin
               rec_in.hi_second = el_ff;
            end
            if (rec_ff.calls != '1) begin
               rec_in.calls = rec_ff.calls + 1'b1;
            end
            state_in = ST_WRITE;
         end

         ST_WRITE: begin
            rec_we   = 1'b1;
            state_in = ST_REPLY;
         end

         ST_REPLY: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_in        = '0;
               rsp_in.status = status_ff;
               if ((status_ff == STATUS_OK) && (cmd_ff != CMD_CLEAR)) begin
                  rsp_in.slot_index    = SLOT_OUT_BITS'(sel_idx_ff);
                  rsp_in.elapsed_ticks = el_ff;
                  rsp_in.total_ticks   = rec_ff.sum;
                  rsp_in.call_total    = rec_ff.calls;
                  rsp_in.min_first     = rec_ff.lo_first;
                  rsp_in.min_second    = rec_ff.lo_second;
                  rsp_in.max_first     = rec_ff.hi_first;
                  rsp_in.max_second    = rec_ff.hi_second;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // clear frees every slot by the next edge
   a_clear_frees: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (cmd_in == CMD_CLEAR)) |=> (used_ff == '0))
      else $error("slots still in use after clear");

   // a full report only when no slot is free
   a_full_all_used: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_REPLY) && (status_ff == STATUS_FULL)) |-> (&used_ff))
      else $error("table full reported with a free slot");

   // error replies carry no slot and no measurement
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && (rsp_ff.status != STATUS_OK))
         |-> ((rsp_ff.slot_index == '0) && (rsp_ff.elapsed_ticks == '0)
              && (rsp_ff.call_total == '0)))
      else $error("error reply with non-zero fields");

endmodule

`default_nettype wire
